// ===== design/jti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jti_pkg
// shared types and codes of the joint trajectory interpolator
// ----------------------------------------------------------------------------
package jti_pkg;

  localparam int unsigned FieldJoints = 5;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_APPEND = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INTERP  = 3'd0,
    ST_START   = 3'd1,
    ST_FINAL   = 3'd2,
    ST_STORED  = 3'd3,
    ST_DROPPED = 3'd4
  } status_e;

  // control from sequencer to the joint lanes
  typedef struct packed {
    logic        load_from;   // capture lane's "from" value
    logic        use_start;   // from value is start pose (else ram data)
    logic        load_to;     // capture lane's "to" value from ram
    logic        mul_go;      // compute product with ratio
    logic        fin_go;      // register final result
    logic [16:0] ratio;
  } lane_ctl_t;

endpackage

// ===== design/jti_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jti_ram
// generic simple dual port ram (one write port, one read port), registered read
// ----------------------------------------------------------------------------
module jti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/jti_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jti_div
// radix-2 restoring divider for the q1.16 ratio, one quotient bit a cycle
// ----------------------------------------------------------------------------
module jti_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] span_i,
  output logic        done_o,
  output logic [16:0] ratio_o
);
  logic [32:0] rem_q, rem_d, trial;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic        zero_q, zero_d;
  logic [31:0] span_q, span_d;

  // num < span always, so 16 steps give floor(num * 65536 / span)
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    span_d = span_q;
    trial  = {rem_q[31:0], 1'b0} - {1'b0, span_q};
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      span_d = span_i;
      quo_d  = '0;
      cnt_d  = '0;
      zero_d = (span_i == '0);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], 1'b0};
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    span_q <= span_d;
  end

  assign done_o  = done_q;
  assign ratio_o = zero_q ? 17'h10000 : {1'b0, quo_q};
endmodule

// ===== design/jti_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jti_lane
// one joint's interpolation: a + floor((b - a) * ratio / 65536)
// ----------------------------------------------------------------------------
module jti_lane (
  input  logic               clk_i,
  input  jti_pkg::lane_ctl_t ctl_i,
  input  logic signed [31:0] start_i,
  input  logic signed [31:0] ram_i,
  output logic signed [31:0] pose_o
);
  logic signed [31:0] from_q, to_q, pose_q;
  logic signed [32:0] diff;
  logic signed [50:0] prod_q;
  logic signed [50:0] sum;

  assign diff = 33'(to_q) - 33'(from_q);
  // arithmetic shift gives the floor
  assign sum  = 51'(from_q) + (prod_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_from) begin
      from_q <= ctl_i.use_start ? start_i : ram_i;
    end
    if (ctl_i.load_to) begin
      to_q <= ram_i;
    end
    if (ctl_i.mul_go) begin
      prod_q <= diff * $signed({1'b0, ctl_i.ratio});
    end
    if (ctl_i.fin_go) begin
      pose_q <= sum[31:0];
    end
  end

  assign pose_o = pose_q;
endmodule

// ===== design/joint_trajectory_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator
// piecewise linear trajectory over stored waypoints, five joint lanes
// ----------------------------------------------------------------------------
// One item at a time. An append, or a query or begin answered with the start
// pose, has its result registered through S_APP or S_FIN. Any other query or
// begin first reads the last stored entry: at or past its time the result is
// that waypoint. Otherwise it scans the waypoint time memory from entry 0,
// through S_SCANW and S_SCAN for each entry (one read port, registered read),
// reads the previous entry's time, then runs a serial ratio division and a
// registered multiply in each of the five joint lanes. The result sits in an
// output register until its transfer; the next item is taken once it is gone.
// No clearing pass is needed: the fill count guards every read.
module joint_trajectory_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        time_now_i,
  input  logic [31:0]        point_time_i,
  input  logic signed [31:0] point_joint0_i,
  input  logic signed [31:0] point_joint1_i,
  input  logic signed [31:0] point_joint2_i,
  input  logic signed [31:0] point_joint3_i,
  input  logic signed [31:0] point_joint4_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] pose_joint0_o,
  output logic signed [31:0] pose_joint1_o,
  output logic signed [31:0] pose_joint2_o,
  output logic signed [31:0] pose_joint3_o,
  output logic signed [31:0] pose_joint4_o
);
  localparam int unsigned Nj = jti_pkg::FieldJoints;
  localparam int unsigned Aw = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned Cw = $clog2(MAX_POINTS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // issue reads of times
  localparam logic [3:0] S_PREV  = 4'd2;  // read previous time
  localparam logic [3:0] S_PREVW = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RDTO  = 4'd5;  // read positions of target
  localparam logic [3:0] S_RDFR  = 4'd6;  // read positions of source
  localparam logic [3:0] S_GRAB  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_APP   = 4'd11;
  localparam logic [3:0] S_LAST  = 4'd12; // compare against last point time
  localparam logic [3:0] S_SCANW = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [Cw-1:0] count_q, count_d;
  logic [31:0] start_time_q, start_time_d;
  logic        start_valid_q, start_valid_d;
  logic signed [31:0] seed_q [Nj];
  logic signed [31:0] start_pose_q [Nj];
  logic signed [31:0] start_sel [Nj];

  // latched item
  logic [1:0]  op_q;
  logic [31:0] now_q, dt_q;
  logic [Aw-1:0] idx_q, idx_d, raddr;   // scan address / found index
  logic [Aw-1:0] hit_q;
  logic        found_q, found_d;
  logic [31:0] prev_t_q, hit_t_q;
  logic [2:0]  status_q, status_d;
  logic        ovalid_q, ovalid_d;
  logic signed [31:0] pose_q [Nj];
  logic signed [31:0] fin_pose [Nj];

  // memories
  logic        t_we;
  logic [31:0] t_rdata;
  logic [31*Nj+Nj-1:0] p_wdata, p_rdata;
  logic [Aw-1:0] waddr;

  jti_pkg::lane_ctl_t ctl;
  logic        div_start, div_done;
  logic [16:0] ratio;
  logic [31:0] div_num, div_span;
  logic signed [31:0] lane_pose [Nj];
  logic signed [31:0] point_in [Nj];
  logic        in_xfer;

  assign point_in[0] = point_joint0_i;
  assign point_in[1] = point_joint1_i;
  assign point_in[2] = point_joint2_i;
  assign point_in[3] = point_joint3_i;
  assign point_in[4] = point_joint4_i;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign in_xfer     = in_valid_i && in_ready_o;

  // seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Nj; j++) seed_q[j] <= '0;
    end else if (cfg_valid_i) begin
      for (int j = 0; j < Nj; j++) begin
        if (cfg_index_i == 3'(j)) seed_q[j] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < Nj; j++) begin
      start_sel[j] = start_valid_q ? start_pose_q[j] : seed_q[j];
    end
  end

  assign waddr = count_q[Aw-1:0];
  assign t_we  = in_xfer && (operation_i == jti_pkg::OP_APPEND) &&
                 (count_q < Cw'(MAX_POINTS));
  always_comb begin
    for (int j = 0; j < Nj; j++) p_wdata[32*j +: 32] = point_in[j];
  end

  jti_ram #(.Width(32), .Depth(MAX_POINTS)) u_time_ram (
    .clk_i(clk_i), .we_i(t_we), .waddr_i(waddr), .wdata_i(point_time_i),
    .raddr_i(raddr), .rdata_o(t_rdata)
  );

  jti_ram #(.Width(32*Nj), .Depth(MAX_POINTS)) u_pos_ram (
    .clk_i(clk_i), .we_i(t_we), .waddr_i(waddr), .wdata_i(p_wdata),
    .raddr_i(raddr), .rdata_o(p_rdata)
  );

  assign div_num  = found_q && (hit_q != '0) ? dt_q - prev_t_q : dt_q;
  assign div_span = found_q && (hit_q != '0) ? hit_t_q - prev_t_q : hit_t_q;

  jti_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(div_num), .span_i(div_span), .done_o(div_done), .ratio_o(ratio)
  );

  for (genvar g = 0; g < Nj; g++) begin : g_lane
    jti_lane u_lane (
      .clk_i(clk_i), .ctl_i(ctl), .start_i(start_sel[g]),
      .ram_i(p_rdata[32*g +: 32]), .pose_o(lane_pose[g])
    );
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    start_time_d  = start_time_q;
    start_valid_d = start_valid_q;
    idx_d         = idx_q;
    found_d       = found_q;
    status_d      = status_q;
    ovalid_d      = ovalid_q;
    raddr         = idx_q;
    div_start     = 1'b0;
    ctl           = '0;
    ctl.ratio     = ratio;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (operation_i == jti_pkg::OP_APPEND) begin
            state_d = S_APP;
            if (count_q < Cw'(MAX_POINTS)) begin
              count_d  = count_q + Cw'(1);
              status_d = jti_pkg::ST_STORED;
            end else begin
              status_d = jti_pkg::ST_DROPPED;
            end
          end else if (time_now_i < start_time_q || count_q == '0) begin
            status_d = jti_pkg::ST_START;
            state_d  = S_FIN;
          end else begin
            // last stored entry decides the final case before any search
            idx_d   = Aw'(count_q - Cw'(1));
            raddr   = Aw'(count_q - Cw'(1));
            found_d = 1'b0;
            state_d = S_LAST;
          end
        end
      end
      S_SCANW: begin
        // idx_q is read again; t_rdata already holds its time
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // t_rdata holds time of entry idx_q; a hit is certain by the last entry
        if (dt_q < t_rdata) begin
          found_d = 1'b1;
          if (idx_q == '0) begin
            state_d = S_DIV;
          end else begin
            raddr   = idx_q - Aw'(1);
            state_d = S_PREVW;
          end
        end else begin
          idx_d   = idx_q + Aw'(1);
          raddr   = idx_q + Aw'(1);
          state_d = S_SCANW;
        end
      end
      S_PREVW: begin
        raddr   = idx_q - Aw'(1);
        state_d = S_PREV;
      end
      S_PREV: begin
        raddr   = idx_q - Aw'(1);
        state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_RDTO;
      end
      S_RDTO: begin
        raddr = idx_q;
        if (div_done) state_d = S_RDFR;
      end
      S_RDFR: begin
        // position data of target now valid
        ctl.load_to = 1'b1;
        raddr       = idx_q - Aw'(1);
        state_d     = S_GRAB;
      end
      S_GRAB: begin
        ctl.load_from = 1'b1;
        ctl.use_start = (idx_q == '0);
        state_d       = S_MUL;
      end
      S_MUL: begin
        ctl.mul_go = 1'b1;
        ctl.fin_go = 1'b0;
        state_d    = S_OUT;
        status_d   = jti_pkg::ST_INTERP;
      end
      S_LAST: begin
        // time and positions of the last entry are on the read ports
        if (dt_q >= t_rdata) begin
          status_d = jti_pkg::ST_FINAL;
          state_d  = S_FIN;
        end else begin
          idx_d   = '0;
          raddr   = '0;
          state_d = S_SCANW;
        end
      end
      S_OUT: begin
        ctl.fin_go = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
        if (op_q == jti_pkg::OP_BEGIN) begin
          start_valid_d = 1'b1;
          start_time_d  = now_q;
          count_d       = '0;
        end
      end
      S_APP: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // pose delivered by the path that finished; a begin latches the same value
  always_comb begin
    for (int j = 0; j < Nj; j++) begin
      if (status_q == jti_pkg::ST_START) fin_pose[j] = start_sel[j];
      else if (status_q == jti_pkg::ST_FINAL) fin_pose[j] = p_rdata[32*j +: 32];
      else fin_pose[j] = lane_pose[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      start_time_q  <= '0;
      start_valid_q <= 1'b0;
      ovalid_q      <= 1'b0;
      for (int j = 0; j < Nj; j++) start_pose_q[j] <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      start_time_q  <= start_time_d;
      start_valid_q <= start_valid_d;
      ovalid_q      <= ovalid_d;
      if (state_q == S_FIN && op_q == jti_pkg::OP_BEGIN) begin
        for (int j = 0; j < Nj; j++) start_pose_q[j] <= fin_pose[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    found_q  <= found_d;
    status_q <= status_d;
    if (in_xfer) begin
      op_q  <= operation_i;
      now_q <= time_now_i;
      dt_q  <= time_now_i - start_time_q;
    end
    if (state_q == S_SCAN && dt_q < t_rdata) begin
      hit_t_q <= t_rdata;
      hit_q   <= idx_q;
    end
    if (state_q == S_PREV) prev_t_q <= t_rdata;
  end

  // output pose register
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Nj; j++) begin
      if (in_xfer) begin
        pose_q[j] <= '0;
      end else if (state_q == S_FIN) begin
        pose_q[j] <= fin_pose[j];
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign status_o      = status_q;
  assign pose_joint0_o = pose_q[0];
  assign pose_joint1_o = pose_q[1];
  assign pose_joint2_o = pose_q[2];
  assign pose_joint3_o = pose_q[3];
  assign pose_joint4_o = pose_q[4];
endmodule

// ===== design/jti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jti_checker
// port level checks of the interpolator, bound to the top level
// ----------------------------------------------------------------------------
module jti_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o
);
  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  // no new item while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'd4)
    else $error("bad status");
endmodule

bind joint_trajectory_interpolator jti_checker u_jti_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o), .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i), .status_o(status_o)
);
